/* sv/fqvd_pkg.sv */
// ----------------------------------------------------------------------------
// fqvd_pkg
// shared types and codes of the value-delete queue: operations, status codes,
// command and response records, back-end states
// ----------------------------------------------------------------------------
package fqvd_pkg;

   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;

   // request mode codes as they arrive on the bus
   localparam logic [1:0] MODE_ENQ = 2'd0;
   localparam logic [1:0] MODE_DEQ = 2'd1;
   localparam logic [1:0] MODE_DEL = 2'd2;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_DEQ,
      OP_DEL,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DEQ_WAIT,
      BK_SCAN,
      BK_SHIFT,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [OCC_W-1:0]         occupancy;
      status_type               status;
      logic signed [DATA_W-1:0] data_out;
   } rsp_type;

endpackage

/* sv/fqvd_ram.sv */
// ----------------------------------------------------------------------------
// fqvd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fqvd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fqvd_front.sv */
// ----------------------------------------------------------------------------
// fqvd_front
// request intake: decodes the mode into an operation and holds up to two
// commands for the back end
// ----------------------------------------------------------------------------
module fqvd_front
   import fqvd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_pop
);

   localparam int QDEPTH = 2;

   cmd_type    slot_ff [QDEPTH];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   // classify
   always_comb begin
      cmd_in.value = req_value;
      unique case (req_mode)
         MODE_ENQ: cmd_in.op = OP_ENQ;
         MODE_DEQ: cmd_in.op = OP_DEQ;
         MODE_DEL: cmd_in.op = OP_DEL;
         default:  cmd_in.op = OP_NOP;
      endcase
   end

   assign req_tready = (fill_ff != 2'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* sv/fqvd_back.sv */
// ----------------------------------------------------------------------------
// fqvd_back
// command execution over a circular buffer in ram: enqueue, dequeue,
// newest-first search and gap closing, plus the response register
// ----------------------------------------------------------------------------
module fqvd_back
   import fqvd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

   back_state_type           state_ff, state_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            idx_ff, idx_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0]        res_data_ff, res_data_in;
   status_type               res_status_ff, res_status_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_ff, out_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic [AW:0]              cnt_m1;
   logic [AW:0]              idx_p1;
   logic                     hit;
   logic                     last_hit;
   logic                     shift_done;
   logic                     out_free;

   // logical position to ram address, head is the oldest entry
   function automatic logic [AW-1:0] phys(input logic [AW:0] pos);
      logic [AW:0] sum;
      sum = {1'b0, head_ff} + pos;
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   fqvd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cnt_m1     = (AW + 1)'(count_ff) - 1'b1;
   assign idx_p1     = {1'b0, idx_ff} + 1'b1;
   assign hit        = (rd_data == $unsigned(value_ff));
   assign last_hit   = ({1'b0, idx_ff} == cnt_m1);
   assign shift_done = (idx_p1 == cnt_m1);
   assign out_free   = !out_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_DEQ:  state_in = (count_ff == '0) ? BK_RESP : BK_DEQ_WAIT;
                  OP_DEL:  state_in = (count_ff == '0) ? BK_RESP : BK_SCAN;
                  default: state_in = BK_RESP;
               endcase
            end
         end
         BK_DEQ_WAIT: state_in = BK_RESP;
         BK_SCAN: begin
            if (hit) begin
               state_in = last_hit ? BK_RESP : BK_SHIFT;
            end else if (idx_ff == '0) begin
               state_in = BK_RESP;
            end
         end
         BK_SHIFT: begin
            if (shift_done) begin
               state_in = BK_RESP;
            end
         end
         BK_RESP: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      cmd_pop       = 1'b0;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_in        = out_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               value_in      = cmd.value;
               res_data_in   = '0;
               res_status_in = ST_OK;
               unique case (cmd.op)
                  OP_ENQ: begin
                     if (count_ff == FULL_C) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys((AW + 1)'(count_ff));
                        wr_data  = $unsigned(cmd.value);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DEQ: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = phys('0);
                     end
                  end
                  OP_DEL: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = phys(cnt_m1);
                        idx_in  = cnt_m1[AW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_DEQ_WAIT: begin
            res_data_in = rd_data;
            head_in     = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in    = count_ff - 1'b1;
         end
         BK_SCAN: begin
            if (hit) begin
               if (last_hit) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys(idx_p1);
               end
            end else if (idx_ff == '0) begin
               res_status_in = ST_NOTFOUND;
            end else begin
               idx_in  = idx_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = phys({1'b0, idx_ff} - 1'b1);
            end
         end
         BK_SHIFT: begin
            // move entry idx+1 down into idx
            wr_en   = 1'b1;
            wr_addr = phys({1'b0, idx_ff});
            wr_data = rd_data;
            if (shift_done) begin
               count_in = count_ff - 1'b1;
            end else begin
               idx_in  = idx_p1[AW-1:0];
               rd_en   = 1'b1;
               rd_addr = phys(idx_p1 + 1'b1);
            end
         end
         BK_RESP: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.data_out  = $signed(res_data_ff);
               out_in.status    = res_status_ff;
               out_in.occupancy = OCC_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      out_ff        <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

endmodule

/* sv/fifo_queue_with_value_delete.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_value_delete
// bounded fifo of signed 32-bit words with enqueue, dequeue and
// delete-first-match-from-newest, one response per request
// ----------------------------------------------------------------------------
// Each request transaction carries an operation in req_tuser (0 enqueue,
// 1 dequeue, 2 delete, 3 no-op) and a word in req_tdata, and yields exactly
// one response transaction with the dequeued word, a status code (ok, empty,
// not found, full) and the occupancy after the operation. A two-entry command
// queue takes requests while the execution engine is busy, and the response
// sits in an output register so the engine can move on while it waits. Words
// live in one simple dual-port ram used as a circular buffer. The engine
// takes one request at a time: enqueue, no-op and any request refused on a
// full or empty queue go straight to the response, a dequeue waits for the
// registered ram read of the oldest word, and a delete on a non-empty queue
// examines entries from the newest (one ram read per cycle, all of them when
// nothing matches) and then moves the newer entries down to close the gap
// (one read and one write per cycle). A response held back by rsp_tready
// stalls the engine when the next response is ready. No clearing pass after
// reset: the entry count alone marks which words are live.
// ----------------------------------------------------------------------------
module fifo_queue_with_value_delete
   import fqvd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [36:32] occupancy, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type rsp;

   // front end: classify requests and buffer them
   fqvd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_value  ($signed(req_tdata)),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // back end: storage, search, gap closing and response register
   fqvd_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // pack response fields onto the bus
   assign rsp_tdata = {3'b000, rsp.occupancy, $unsigned(rsp.data_out)};
   assign rsp_tuser = rsp.status;

endmodule

/* sv/fqvd_checker.sv */
// ----------------------------------------------------------------------------
// fqvd_checker
// port-level checks of the value-delete queue, bound to the top level
// ----------------------------------------------------------------------------
module fqvd_checker
   import fqvd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   localparam bit OCC_EXACT = (DEPTH < 32);

   logic [4:0] occ;
   logic       req_fire;

   assign occ      = rsp_tdata[36:32];
   assign req_fire = req_tvalid && req_tready;

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // data is only returned with an ok status
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("data on error response");

   // full report means the queue really holds DEPTH entries
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL && OCC_EXACT |-> occ == 5'(DEPTH))
      else $error("full status with wrong occupancy");

   // empty report means nothing is held
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> occ == 5'd0)
      else $error("empty status with nonzero occupancy");

   // a request accepted right after reset cannot be answered in the cycle after it
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) && req_fire |=> !rsp_tvalid)
      else $error("response before any request could finish");

endmodule

bind fifo_queue_with_value_delete fqvd_checker #(
   .DEPTH (DEPTH)
) u_fqvd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
